[sv/spq_pkg.sv]
// Package for the sorted priority queue: sizes, entry and control types, status codes.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int VALUE_W       = 32;
    localparam int PRIO_IN_W     = 16;
    localparam int OCC_W         = 5;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [PRIORITY_BITS-1:0] prio_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        prio_t                     prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted queue: holds an entry and shifts towards or away from the head.
// Depends on spq_pkg.
`default_nettype none

module spq_cell (
    input  wire logic               clk,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  wire logic               valid,
    input  wire logic               left_before,
    input  spq_pkg::entry_t         left_entry,
    input  spq_pkg::entry_t         right_entry,
    output spq_pkg::entry_t         entry,
    output logic                    ahead
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    assign ahead = valid && (entry_reg.prio < ctrl.new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.enq)
        begin
            priority if (ahead)
                entry_next = entry_reg;
            else if (left_before)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

[sv/sorted_priority_queue.sv]
// Top level of the sorted priority queue: stream ports, entry count and the chain of cells.
// Depends on spq_pkg and spq_cell.
// An item's result is registered and presented in the cycle after the transaction is accepted.
// Throughput: one item per cycle; the row of cells inserts or shifts in a single step.
// The input stalls only while a result waits in the output register and is not taken.
// Reset clears the entry count and the output valid flag; stored entries are left as they are.
`default_nettype none

module sorted_priority_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // value [31:0], priority_req [47:32]
    input  wire logic [0:0]  s_axis_tuser,  // mode [0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // out_value [31:0], occupancy [36:32], zero [39:37]
    output logic [1:0]       m_axis_tuser   // status [1:0]
);
    import spq_pkg::*;

    count_t                    count_reg;
    count_t                    count_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;
    status_t                   status_reg;
    status_t                   status_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic [PRIORITY_BITS+PRIO_IN_W-1:0] prio_ext;
    cell_ctrl_t                ctrl;
    entry_t                    cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]    cell_before;
    logic [COUNT_W+OCC_W-1:0]  occ_ext;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty         = (count_reg == '0);
    assign prio_ext      = {{PRIORITY_BITS{1'b0}}, s_axis_tdata[47:32]};

    assign ctrl.enq                  = accept && !s_axis_tuser[0] && !full;
    assign ctrl.deq                  = accept && s_axis_tuser[0] && !empty;
    assign ctrl.new_entry.value      = s_axis_tdata[31:0];
    assign ctrl.new_entry.prio       = prio_ext[PRIORITY_BITS-1:0];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_before;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_before = 1'b1;
            assign left_entry  = cell_entry[i];
        end
        else
        begin : g_body
            assign left_before = cell_before[i-1];
            assign left_entry  = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (COUNT_W'(i) < count_reg),
            .left_before (left_before),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .ahead       (cell_before[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            unique case (s_axis_tuser[0])
                1'b0:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next = ST_ENQUEUED;
                        count_next  = count_reg + COUNT_W'(1);
                    end
                end
                1'b1:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        status_next    = ST_DEQUEUED;
                        out_value_next = cell_entry[0].value;
                        count_next     = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
    end

    assign occ_ext       = {{OCC_W{1'b0}}, count_reg};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, occ_ext[OCC_W-1:0], out_value_reg};
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

[tb/sv/tb_sorted_priority_queue.sv]
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue: directed and random enqueue and dequeue traffic is
// checked against a shadow copy of the sorted queue, under several idling and stall phases.
// Depends on spq_pkg and the sorted_priority_queue RTL; it reads no files.

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    typedef struct {
        logic signed [VALUE_W-1:0] out_value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    logic signed [VALUE_W-1:0] shadow_value [QUEUE_DEPTH];
    prio_t                     shadow_prio  [QUEUE_DEPTH];
    int                        shadow_count;
    queue_result_t             pending_results [$];
    int                        error_count;
    int                        send_idle_pct;
    int                        recv_stall_pct;
    int                        hold_off_cycles;

    sorted_priority_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic queue_result_t apply_to_shadow_queue(input logic mode,
                                                            input logic signed [31:0] value,
                                                            input logic [PRIO_IN_W-1:0] prio_in);
        queue_result_t res;
        prio_t         prio;
        int            pos;
        prio = prio_t'(prio_in);
        res.out_value = '0;
        if (mode == MODE_ENQ)
        begin
            if (shadow_count >= QUEUE_DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] < prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = value;
                shadow_prio[pos]  = prio;
                shadow_count++;
                res.status = ST_ENQUEUED;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.out_value = shadow_value[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1]  = shadow_prio[i];
                end
                shadow_count--;
                res.status = ST_DEQUEUED;
            end
        end
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic mode, input logic signed [31:0] value,
                             input logic [PRIO_IN_W-1:0] prio_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {prio_in, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_to_shadow_queue(mode, value, prio_in));
        @(negedge clk);
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        queue_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("Result with no transaction outstanding: tdata %h, tuser %h",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_res.out_value)
                begin
                    $error("out_value: expected %0d, actual %0d",
                           exp_res.out_value, $signed(m_axis_tdata[31:0]));
                    error_count++;
                end
                if (m_axis_tuser !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[36:32] !== exp_res.occupancy)
                begin
                    $error("occupancy: expected %0d, actual %0d",
                           exp_res.occupancy, m_axis_tdata[36:32]);
                    error_count++;
                end
                if (m_axis_tdata[39:37] !== 3'b000)
                begin
                    $error("padding: expected 0, actual %0d", m_axis_tdata[39:37]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_ordering();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(MODE_DEQ, 32'h1234_5678, 16'h0000);
        send_item(MODE_ENQ, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(MODE_ENQ, 32'h8000_0000, 16'h0000);
        send_item(MODE_ENQ, 32'hFFFF_FFFF, 16'h0000);
        send_item(MODE_ENQ, 32'h0000_0000, 16'h8000);
        send_item(MODE_ENQ, 32'h5555_5555, 16'h5555);
        send_item(MODE_ENQ, 32'hAAAA_AAAA, 16'hAAAA);
    endtask

    task automatic test_full_queue();
        for (int k = 0; k < QUEUE_DEPTH - 6; k++)
            send_item(MODE_ENQ, $urandom, (k % 3 == 0) ? 16'h8000 : 16'($urandom));
        send_item(MODE_ENQ, 32'hDEAD_BEEF, 16'h0000);
        repeat (4)
            send_item(MODE_DEQ, $urandom, 16'($urandom));
    endtask

    task automatic run_random_traffic(input int n_items);
        int                   enq_pct;
        int                   prio_kind;
        logic                 mode;
        logic [PRIO_IN_W-1:0] prio;
        enq_pct   = 50;
        prio_kind = 0;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 25 == 0)
            begin
                enq_pct   = 20 + 30 * $urandom_range(2);
                prio_kind = $urandom_range(2);
            end
            mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
            case (prio_kind)
                0:       prio = PRIO_IN_W'($urandom_range(3));
                1:       prio = PRIO_IN_W'($urandom);
                default: prio = $urandom_range(1) ? '1 : '0;
            endcase
            send_item(mode, $urandom, prio);
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_traffic(375);
        send_idle_pct  = 46;
        recv_stall_pct = 0;
        run_random_traffic(375);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_random_traffic(375);
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        run_random_traffic(375);
    endtask

    task automatic test_input_stall();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 60;
        run_random_traffic(40);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        shadow_count    = 0;
        error_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_ordering();
        test_full_queue();
        test_input_stall();
        test_random_phases();

        s_axis_tvalid  = 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5)
            @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
